@@ src/cds_pkg.sv @@
// Shared types and constants for the contact distance score block.
package cds_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int SQRT_STEPS      = 32;
  localparam int EXP_BITS        = 20;
  localparam int NUM_W           = 64;
  localparam int DEN_W           = 48;

  localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;
  localparam logic [62:0] F0_Q62  = 63'h4000_0000_0000_0000 - 63'h0000_4000_0000_0000
                                    + 63'h0000_0000_2000_0000 - 63'd2731;
  localparam logic [63:0] E_Q16        = 64'd178145;
  localparam logic [16:0] TAIL_LIMIT   = 17'd4096;
  localparam logic [47:0] RATIO_LIMIT  = 48'd720896;
  localparam logic [30:0] SCORE_MAX    = 31'h7FFF_FFFF;
  localparam logic [39:0] TOTAL_MAX    = 40'hFF_FFFF_FFFF;
  localparam logic [15:0] MID_RESET    = 16'd2048;
  localparam logic [15:0] CUT_RESET    = 16'd5120;

  localparam logic REG_MIDPOINT = 1'b0;
  localparam logic REG_CUTOFF   = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic {MUL_ACC, MUL_SQ} mul_sel_t;
  typedef enum logic [1:0] {DIV_SIG, DIV_RATIO, DIV_EPOS} div_sel_t;

  typedef struct packed {
    logic       load;
    logic       sq_step;
    logic [1:0] axis;
    logic       sqrt_step;
    logic       sqrt_round;
    logic       sig_prep;
    logic       pen_prep;
    logic [4:0] exp_idx;
    logic       mul_start;
    mul_sel_t   mul_sel;
    logic       e30_calc;
    logic       x_calc;
    logic       div_start;
    div_sel_t   div_sel;
    logic       base1;
    logic       base2;
    logic       score;
    logic       emit;
  } cds_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic ubit;
    logic tail;
    logic far;
    logic rbig;
  } cds_sts_t;

endpackage

@@ src/contact_distance_score_core.sv @@
// Top level of the contact distance score block.
//
// Input channel (in_valid/in_ready) takes one contact: two atom positions,
// a probability and a last marker. Output channel (out_valid/out_ready)
// returns one result per contact: contact score, running total, last flag.
// Config channel (cfg_valid/cfg_ready) writes index 0 midpoint distance and
// index 1 cutoff distance; cfg_ready is always high.
// One contact at a time: the three axis squares, the square-root steps, then
// for the sigmoid up to 20 exponent steps on the shared Q.62 multiplier
// and a divide; far contacts add a ratio divide and, unless the ratio
// reaches its limit, a second exponent run and a reciprocal divide.
// The result sits in an output register; the next contact is accepted while
// it waits. A stalled receiver holds the next result in the controller
// until the register frees. Reset clears the total and loads defaults.
module contact_distance_score_core #(
  parameter int COORD_WIDTH = cds_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic [16:0]                   probability,
  input  logic                          last_contact,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [30:0]                   contact_score,
  output logic [39:0]                   total_score,
  output logic                          last_out
);
  import cds_pkg::*;

  cds_cmd_t cmd;
  cds_sts_t sts;

  assign cfg_ready = 1'b1;

  cds_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  cds_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .probability(probability), .last_contact(last_contact),
    .cmd(cmd), .sts(sts), .contact_score(contact_score),
    .total_score(total_score), .last_out(last_out)
  );
endmodule

@@ src/cds_mul.sv @@
// Rounded Q.62 multiplier built from four 32x32 partial products.
module cds_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] a,
  input  logic [62:0] b,
  output logic        done,
  output logic [62:0] res
);
  logic [62:0]  a_r, b_r;
  logic [2:0]   step;
  logic         busy;
  logic [31:0]  pa, pb;
  logic [63:0]  prod;
  logic [127:0] acc, prod_sh, rnd;

  assign pa = step[1] ? {1'b0, a_r[62:32]} : a_r[31:0];
  assign pb = step[0] ? {1'b0, b_r[62:32]} : b_r[31:0];

  always_comb begin
    case (step)
      3'd1:    prod_sh = {64'd0, prod};
      3'd4:    prod_sh = {prod, 64'd0};
      default: prod_sh = {32'd0, prod, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd5) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (busy) begin
      if (step < 3'd4) prod <= pa * pb;
      if (step >= 3'd1 && step <= 3'd4) acc <= acc + prod_sh;
    end
  end

  assign rnd  = acc + (128'd1 << 61);
  assign res  = rnd[124:62];
  assign done = busy && (step == 3'd5);
endmodule

@@ src/cds_div.sv @@
// Restoring divider, one quotient bit per cycle.
module cds_div #(
  parameter int NW = cds_pkg::NUM_W,
  parameter int DW = cds_pkg::DEN_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW);

  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem, rem_sh;
  logic [CW-1:0] cnt;
  logic          busy;

  assign rem_sh = {rem[DW-1:0], num_r[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(NW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_r}) begin
        rem <= rem_sh - {1'b0, den_r};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end
endmodule

@@ src/cds_datapath.sv @@
// Datapath: distance, sigmoid, penalty, score and running total.
module cds_datapath #(
  parameter int COORD_WIDTH = cds_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic [16:0]                   probability,
  input  logic                          last_contact,
  input  cds_pkg::cds_cmd_t             cmd,
  output cds_pkg::cds_sts_t             sts,
  output logic [30:0]                   contact_score,
  output logic [39:0]                   total_score,
  output logic                          last_out
);
  import cds_pkg::*;

  function automatic logic [63:0] absd(input logic signed [COORD_WIDTH-1:0] a,
                                       input logic signed [COORD_WIDTH-1:0] b);
    logic signed [COORD_WIDTH:0] da, db, df;
    logic [COORD_WIDTH:0] m;
    da = a;
    db = b;
    df = da - db;
    m  = df[COORD_WIDTH] ? unsigned'(-df) : unsigned'(df);
    return 64'(m);
  endfunction

  logic [15:0] mid, cut;
  logic [39:0] running;
  logic [29:0] dabs_x, dabs_y, dabs_z, dsel;
  logic [59:0] dsq;
  logic        big, last_r, tail_r, pos;
  logic [16:0] p;
  logic [63:0] sq_v, sq_r, sq_bit, sq_rb;
  logic [31:0] d;
  logic [19:0] u;
  logic [62:0] exp_acc, exp_f, mul_a, mul_res;
  mul_sel_t    mul_sel_r;
  div_sel_t    div_sel_r;
  logic [30:0] e30;
  logic [46:0] x;
  logic [16:0] s;
  logic [47:0] rq;
  logic [63:0] epos, pen, div_num, div_quo;
  logic [47:0] div_den;
  logic [33:0] m1;
  logic [33:0] ps;
  logic [18:0] base;
  logic [30:0] score;
  logic [15:0] cut_eff, deff;
  logic signed [16:0] t;
  logic [16:0] mag;
  logic [31:0] den_sig;
  logic [63:0] dx64, dy64, dz64, acc_rnd;
  logic [64:0] score_sum;
  logic [40:0] total_sum;
  logic [39:0] total;
  logic        mul_done, div_done;

  assign cut_eff = (cut == 16'd0) ? 16'd1 : cut;
  assign deff    = (d < {16'd0, cut_eff}) ? d[15:0] : cut_eff;
  assign t       = signed'({1'b0, mid}) - signed'({1'b0, deff});
  assign mag     = t[16] ? unsigned'(-t) : unsigned'(t);
  assign den_sig = 32'h4000_0000 + 32'(e30);
  assign sq_rb   = sq_r + sq_bit;
  assign dx64    = absd(first_x, second_x);
  assign dy64    = absd(first_y, second_y);
  assign dz64    = absd(first_z, second_z);
  assign acc_rnd = 64'(exp_acc) + 64'h8000_0000;
  assign dsq     = dsel * dsel;
  assign ps      = p * s;

  always_comb begin
    case (cmd.axis)
      AXIS_X:  dsel = dabs_x;
      AXIS_Y:  dsel = dabs_y;
      AXIS_Z:  dsel = dabs_z;
      default: dsel = '0;
    endcase
  end

  always_comb begin
    case (div_sel_t'(cmd.div_sel))
      DIV_SIG: begin
        div_den = 48'(den_sig);
        div_num = pos ? ({17'd0, e30, 16'd0} + 64'(den_sig[31:1]))
                      : (64'h0000_4000_0000_0000 + 64'(den_sig[31:1]));
      end
      DIV_RATIO: begin
        div_den = 48'(cut_eff);
        div_num = {16'd0, d, 16'd0} + 64'(cut_eff[15:1]);
      end
      DIV_EPOS: begin
        div_den = 48'(x);
        div_num = 64'h4000_0000_0000_0000 + 64'(x[46:1]);
      end
      default: begin
        div_den = 48'd1;
        div_num = '0;
      end
    endcase
  end

  assign mul_a = (cmd.mul_sel == MUL_ACC) ? exp_acc : exp_f;

  cds_mul u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(mul_a), .b(exp_f),
    .done(mul_done), .res(mul_res)
  );

  cds_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign pen       = (epos > E_Q16) ? (epos - E_Q16) : 64'd0;
  assign score_sum = 65'(base) + 65'(pen);
  assign total_sum = 41'(running) + 41'(score);
  assign total     = total_sum[40] ? TOTAL_MAX : total_sum[39:0];

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.ubit     = (cmd.exp_idx < 5'(EXP_BITS)) ? u[cmd.exp_idx] : 1'b0;
  assign sts.tail     = mag >= TAIL_LIMIT;
  assign sts.far      = d >= {16'd0, cut_eff};
  assign sts.rbig     = rq >= RATIO_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid     <= MID_RESET;
      cut     <= CUT_RESET;
      running <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIDPOINT: mid <= cfg_data;
          REG_CUTOFF:   cut <= cfg_data;
          default:      ;
        endcase
      end
      if (cmd.emit) running <= last_r ? 40'd0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dabs_x <= dx64[29:0];
      dabs_y <= dy64[29:0];
      dabs_z <= dz64[29:0];
      big    <= (dx64 >= 64'h4000_0000) || (dy64 >= 64'h4000_0000) ||
                (dz64 >= 64'h4000_0000);
      p      <= (probability > 17'd65536) ? 17'd65536 : probability;
      last_r <= last_contact;
      sq_v   <= '0;
      sq_r   <= '0;
      sq_bit <= 64'h4000_0000_0000_0000;
    end
    if (cmd.sq_step) sq_v <= sq_v + 64'(dsq);
    if (cmd.sqrt_step) begin
      if (sq_v >= sq_rb) begin
        sq_v <= sq_v - sq_rb;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.sqrt_round) begin
      if (big) d <= 32'h7FFF_FFFF;
      else     d <= (sq_v > sq_r) ? sq_r[31:0] + 32'd1 : sq_r[31:0];
    end
    if (cmd.sig_prep) begin
      u       <= {mag[11:0], 8'd0};
      tail_r  <= mag >= TAIL_LIMIT;
      pos     <= !t[16];
      exp_acc <= ONE_Q62;
      exp_f   <= F0_Q62;
    end
    if (cmd.pen_prep) begin
      u       <= rq[19:0];
      exp_acc <= ONE_Q62;
      exp_f   <= F0_Q62;
    end
    if (cmd.mul_start) mul_sel_r <= cmd.mul_sel;
    if (mul_done) begin
      if (mul_sel_r == MUL_ACC) exp_acc <= mul_res;
      else                      exp_f   <= mul_res;
    end
    if (cmd.e30_calc) e30 <= tail_r ? 31'd0 : acc_rnd[62:32];
    if (cmd.x_calc)   x   <= 47'((64'(exp_acc) + 64'd32768) >> 16);
    if (cmd.div_start) div_sel_r <= div_sel_t'(cmd.div_sel);
    if (div_done) begin
      case (div_sel_r)
        DIV_SIG:   s    <= div_quo[16:0];
        DIV_RATIO: rq   <= div_quo[47:0];
        DIV_EPOS:  epos <= div_quo;
        default:   ;
      endcase
    end
    if (cmd.base1) m1 <= (17'd65536 - p) * (17'd65536 - s);
    if (cmd.base2) base <= 19'((35'(m1) + 35'(ps) + 35'd32768) >> 16);
    if (cmd.score) begin
      if (!sts.far)      score <= 31'(base);
      else if (sts.rbig) score <= SCORE_MAX;
      else if (score_sum > 65'(SCORE_MAX)) score <= SCORE_MAX;
      else               score <= score_sum[30:0];
    end
    if (cmd.emit) begin
      contact_score <= score;
      total_score   <= total;
      last_out      <= last_r;
    end
  end
endmodule

@@ src/cds_ctrl.sv @@
// Controller state machine sequencing the datapath for one contact.
module cds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output cds_pkg::cds_cmd_t   cmd,
  input  cds_pkg::cds_sts_t   sts
);
  import cds_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE    = 23'h000001, S_SQ      = 23'h000002, S_SQRT    = 23'h000004,
    S_ROUND   = 23'h000008, S_SIGPREP = 23'h000010, S_EXP_TEST = 23'h000020,
    S_EXP_WA  = 23'h000040, S_EXP_SQ  = 23'h000080, S_EXP_WF  = 23'h000100,
    S_E30     = 23'h000200, S_SDIV    = 23'h000400, S_SDIV_W  = 23'h000800,
    S_BASE1   = 23'h001000, S_BASE2   = 23'h002000, S_RDIV    = 23'h004000,
    S_RDIV_W  = 23'h008000, S_RCHK    = 23'h010000, S_PENPREP = 23'h020000,
    S_XCALC   = 23'h040000, S_EDIV    = 23'h080000, S_EDIV_W  = 23'h100000,
    S_SCORE   = 23'h200000, S_EMIT    = 23'h400000
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       pen_phase, pen_phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pen_phase_next = pen_phase;
    cmd            = '0;
    cmd.axis       = cnt[1:0];
    cmd.exp_idx    = cnt[4:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cnt_next    = cnt + 6'd1;
        if (cnt == 6'd2) begin
          cnt_next   = '0;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 6'd1;
        if (cnt == 6'(SQRT_STEPS - 1)) state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.sqrt_round = 1'b1;
        state_next     = S_SIGPREP;
      end
      S_SIGPREP: begin
        cmd.sig_prep   = 1'b1;
        cnt_next       = '0;
        pen_phase_next = 1'b0;
        state_next     = sts.tail ? S_E30 : S_EXP_TEST;
      end
      S_EXP_TEST: begin
        if (cnt == 6'(EXP_BITS)) begin
          state_next = pen_phase ? S_XCALC : S_E30;
        end else if (sts.ubit) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_ACC;
          state_next    = S_EXP_WA;
        end else begin
          state_next = S_EXP_SQ;
        end
      end
      S_EXP_WA: if (sts.mul_done) state_next = S_EXP_SQ;
      S_EXP_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_SQ;
        state_next    = S_EXP_WF;
      end
      S_EXP_WF: begin
        if (sts.mul_done) begin
          cnt_next   = cnt + 6'd1;
          state_next = S_EXP_TEST;
        end
      end
      S_E30: begin
        cmd.e30_calc = 1'b1;
        state_next   = S_SDIV;
      end
      S_SDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SIG;
        state_next    = S_SDIV_W;
      end
      S_SDIV_W: begin
        cmd.div_sel = DIV_SIG;
        if (sts.div_done) state_next = S_BASE1;
      end
      S_BASE1: begin
        cmd.base1  = 1'b1;
        state_next = S_BASE2;
      end
      S_BASE2: begin
        cmd.base2  = 1'b1;
        state_next = sts.far ? S_RDIV : S_SCORE;
      end
      S_RDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATIO;
        state_next    = S_RDIV_W;
      end
      S_RDIV_W: begin
        cmd.div_sel = DIV_RATIO;
        if (sts.div_done) state_next = S_RCHK;
      end
      S_RCHK: state_next = sts.rbig ? S_SCORE : S_PENPREP;
      S_PENPREP: begin
        cmd.pen_prep   = 1'b1;
        cnt_next       = '0;
        pen_phase_next = 1'b1;
        state_next     = S_EXP_TEST;
      end
      S_XCALC: begin
        cmd.x_calc = 1'b1;
        state_next = S_EDIV;
      end
      S_EDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_EPOS;
        state_next    = S_EDIV_W;
      end
      S_EDIV_W: begin
        cmd.div_sel = DIV_EPOS;
        if (sts.div_done) state_next = S_SCORE;
      end
      S_SCORE: begin
        cmd.score  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pen_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pen_phase <= pen_phase_next;
      if (cmd.emit)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready)) else $error("emit over held result");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid) else $error("result not presented");
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SQ)) else $error("transfer not started");
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !sts.mul_done) else $error("multiplier restarted at done");
`endif
endmodule
